@@ design/dnrs_pkg.sv @@
// Shared constants and codes for the directional nearest rectangle selector.
package dnrs_pkg;

	localparam int COORD_BITS_DEF   = 16;
	localparam int ID_BITS_DEF      = 16;
	localparam int OFF_AXIS_PENALTY = 1000000;
	localparam int USER_BITS        = 8;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_CAND  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		DIR_N  = 3'd0,
		DIR_NE = 3'd1,
		DIR_E  = 3'd2,
		DIR_SE = 3'd3,
		DIR_S  = 3'd4,
		DIR_SW = 3'd5,
		DIR_W  = 3'd6,
		DIR_NW = 3'd7
	} dir_t;

endpackage

@@ design/directional_nearest_rect_select_top.sv @@
// Top level of the directional nearest rectangle selector.
//
// Input stream: a start item (tuser func = 0) loads the reference rectangle,
// its id and a direction; candidate items (func = 1) follow. The item with
// tlast set closes the search and yields one result item on the output
// stream: the best candidate id, or the reference id with found clear.
// Items without tlast give no result.
//
// One input item per cycle is taken when the output is not stalled. Each
// item is registered, then scored and folded into the best-so-far register;
// a last item also loads the result register, where the result waits until
// it is taken. The block keeps accepting while a result waits on the output,
// until a second last item has to wait behind it; then s_tready drops.
//
// Reset clears the reference (center 0,0, id 0, north), the best candidate
// and both stream stages. After each result the search restarts against the
// same reference.
module directional_nearest_rect_select_top
	import dnrs_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ID_BITS    = ID_BITS_DEF,
	localparam int IN_DATA_BITS  = ((4 * COORD_BITS + ID_BITS + 3 + 7) / 8) * 8,
	localparam int OUT_DATA_BITS = ((ID_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// rect_x, rect_y, rect_width, rect_height, window_id, direction[2:0], zero fill
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// func, eligible, zero fill
	input  logic [USER_BITS-1:0]     s_tuser,
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// best_id, zero fill
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	// found, zero fill
	output logic [USER_BITS-1:0]     m_tuser
);

	localparam int CW = COORD_BITS + 1;
	localparam int W  = COORD_BITS + 4;
	localparam int SCORE_BITS =
		$clog2((64'd1 << (COORD_BITS + 2)) + 64'(OFF_AXIS_PENALTY) + 64'd1);

	logic                         valid_s1;
	func_t                        func_s1;
	logic signed [COORD_BITS-1:0] rect_x_s1;
	logic signed [COORD_BITS-1:0] rect_y_s1;
	logic [COORD_BITS-1:0]        rect_w_s1;
	logic [COORD_BITS-1:0]        rect_h_s1;
	logic [ID_BITS-1:0]           id_s1;
	logic                         elig_s1;
	dir_t                         dir_s1;
	logic                         last_s1;

	logic signed [CW-1:0]         ref_cx_q;
	logic signed [CW-1:0]         ref_cy_q;
	logic [ID_BITS-1:0]           ref_id_q;
	dir_t                         dir_q;
	logic                         have_best_q;
	logic [SCORE_BITS-1:0]        low_score_q;
	logic [ID_BITS-1:0]           best_id_q;

	logic                         out_valid_q;
	logic [ID_BITS-1:0]           out_id_q;
	logic                         out_found_q;

	logic                         out_free;
	logic                         proc;
	logic                         is_start;
	logic signed [CW-1:0]         cx;
	logic signed [CW-1:0]         cy;
	logic signed [CW:0]           hx;
	logic signed [CW:0]           hy;
	logic signed [CW+1:0]         rx;
	logic signed [CW+1:0]         ry;
	logic signed [W-1:0]          ax;
	logic signed [W-1:0]          ay;
	logic signed [W-1:0]          abs_x;
	logic signed [W-1:0]          abs_y;
	logic                         vert;
	logic                         neg_dist;
	logic signed [W-1:0]          along;
	logic signed [W-1:0]          off;
	logic signed [W-1:0]          sum;
	logic [SCORE_BITS-1:0]        score;
	logic                         cand_ok;
	logic                         take;

	assign out_free = !out_valid_q || m_tready;
	assign proc     = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || proc;
	assign is_start = (func_s1 == FUNC_START);

	always_comb begin
		cx = $signed({rect_x_s1[COORD_BITS-1], rect_x_s1})
			+ $signed({2'b00, rect_w_s1[COORD_BITS-1:1]});
		cy = $signed({rect_y_s1[COORD_BITS-1], rect_y_s1})
			+ $signed({2'b00, rect_h_s1[COORD_BITS-1:1]});
		hx = $signed({cx[CW-1], cx}) - $signed({ref_cx_q[CW-1], ref_cx_q});
		hy = $signed({cy[CW-1], cy}) - $signed({ref_cy_q[CW-1], ref_cy_q});
		// diagonals: rotate by 45 degrees
		if (dir_q == DIR_NE || dir_q == DIR_SE ||
			dir_q == DIR_SW || dir_q == DIR_NW) begin
			rx = $signed({hx[CW], hx}) + $signed({hy[CW], hy});
			ry = $signed({hy[CW], hy}) - $signed({hx[CW], hx});
		end else begin
			rx = $signed({hx[CW], hx});
			ry = $signed({hy[CW], hy});
		end
		ax    = $signed({rx[CW+1], rx});
		ay    = $signed({ry[CW+1], ry});
		abs_x = ax[W-1] ? -ax : ax;
		abs_y = ay[W-1] ? -ay : ay;
		vert  = (dir_q == DIR_N || dir_q == DIR_NE ||
			dir_q == DIR_S || dir_q == DIR_SW);
		neg_dist = (dir_q == DIR_N || dir_q == DIR_NE ||
			dir_q == DIR_W || dir_q == DIR_NW);
		if (vert) begin
			off   = abs_x;
			along = neg_dist ? -ay : ay;
		end else begin
			off   = abs_y;
			along = neg_dist ? -ax : ax;
		end
		sum   = along + off;
		score = SCORE_BITS'(sum[COORD_BITS+2:0])
			+ ((off > along) ? SCORE_BITS'(OFF_AXIS_PENALTY) : SCORE_BITS'(0));
		cand_ok = !is_start && elig_s1 && (id_s1 != ref_id_q) && (along > 0);
		take    = cand_ok && (!have_best_q || score < low_score_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1   <= func_t'(s_tuser[0]);
			elig_s1   <= s_tuser[1];
			dir_s1    <= dir_t'(s_tdata[4*COORD_BITS+ID_BITS+2:4*COORD_BITS+ID_BITS]);
			rect_x_s1 <= s_tdata[COORD_BITS-1:0];
			rect_y_s1 <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			rect_w_s1 <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
			rect_h_s1 <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
			id_s1     <= s_tdata[4*COORD_BITS+ID_BITS-1:4*COORD_BITS];
			last_s1   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_cx_q    <= '0;
			ref_cy_q    <= '0;
			ref_id_q    <= '0;
			dir_q       <= DIR_N;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (proc) begin
				if (is_start) begin
					ref_cx_q    <= cx;
					ref_cy_q    <= cy;
					ref_id_q    <= id_s1;
					dir_q       <= dir_s1;
					have_best_q <= 1'b0;
				end else if (take) begin
					have_best_q <= 1'b1;
				end
				if (last_s1) begin
					have_best_q <= 1'b0;
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && take) begin
			low_score_q <= score;
			best_id_q   <= id_s1;
		end
		if (proc && last_s1) begin
			if (is_start || take) begin
				out_id_q <= id_s1;
			end else if (have_best_q) begin
				out_id_q <= best_id_q;
			end else begin
				out_id_q <= ref_id_q;
			end
			out_found_q <= !is_start && (take || have_best_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_BITS'(out_id_q);
	assign m_tuser  = USER_BITS'(out_found_q);

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && last_s1 && out_valid_q && !m_tready)
		else $error("input stalled without a waiting last item");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> m_tvalid)
		else $error("last item did not produce a result");

	a_start_clears_best: assert property (@(posedge clk) disable iff (!arst_n)
		proc && is_start |=> !have_best_q)
		else $error("start item left a best candidate");

	a_found_not_ref: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 && !is_start |=> !m_tuser[0] || (m_tdata[ID_BITS-1:0] != ref_id_q))
		else $error("found result names the reference id");

endmodule
